// ===== design/preemptive_priority_scheduler_assert.svh =====
// Assertion macros for the preemptive priority scheduler.
// Expects clk and rst in scope at the point of use.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define PPS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pps: implication check failed");
`define PPS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pps: next-cycle check failed");
`else
`define PPS_ASSERT_IMP(name, ante, cons)
`define PPS_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ===== design/pps_pkg.sv =====
// Shared constants and types for the preemptive priority scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pps_pkg;
  localparam int MAX_PROCESSES = 32;
  localparam int CNT_W    = $clog2(MAX_PROCESSES + 1);
  localparam int IDX_W    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int PRIO_W   = 8;
  localparam int ARR_W    = 16;
  localparam int BURST_W  = 16;
  localparam int PID_W    = 5;
  localparam int FINISH_W = 22;
  localparam int TAT_W    = 21;
  localparam int WAIT_W   = 21;
  // worst case: last arrival plus every burst back to back
  localparam int TICK_W   = $clog2((MAX_PROCESSES + 1) * (2 ** BURST_W));

  // scan token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [IDX_W-1:0]   idx;
    logic [PRIO_W-1:0]  prio;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] rem;
    logic [BURST_W-1:0] burst;
    logic               nfound;
    logic [ARR_W-1:0]   narr;
  } scan_tok_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [PRIO_W-1:0]  prio;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
  } load_wr_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [BURST_W-1:0] rem;
    logic               done;
  } upd_wr_t;
endpackage
`default_nettype wire

// ===== design/pps_ifs.sv =====
// Valid/ready channel interfaces for process entries and results.
// Depends on pps_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pps_entry_if;
  import pps_pkg::*;
  logic               valid;
  logic               ready;
  logic [PRIO_W-1:0]  priority_level;
  logic [ARR_W-1:0]   arrival_tick;
  logic [BURST_W-1:0] burst_ticks;
  logic               final_entry;
  modport source(output valid, priority_level, arrival_tick, burst_ticks, final_entry,
                 input ready);
  modport sink(input valid, priority_level, arrival_tick, burst_ticks, final_entry,
               output ready);
endinterface

interface pps_result_if;
  import pps_pkg::*;
  logic                valid;
  logic                ready;
  logic [PID_W-1:0]    process_id;
  logic [FINISH_W-1:0] finish_tick;
  logic [TAT_W-1:0]    turnaround_ticks;
  logic [WAIT_W-1:0]   waiting_ticks;
  logic                last_result;
  modport source(output valid, process_id, finish_tick, turnaround_ticks, waiting_ticks,
                 last_result, input ready);
  modport sink(input valid, process_id, finish_tick, turnaround_ticks, waiting_ticks,
               last_result, output ready);
endinterface
`default_nettype wire

// ===== design/pps_cell.sv =====
// One scheduler cell: holds one process entry and folds it into the scan token.
// Depends on pps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pps_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [pps_pkg::IDX_W-1:0]  cell_index,
  input  wire logic [pps_pkg::CNT_W-1:0]  load_cnt,
  input  wire logic [pps_pkg::TICK_W-1:0] tick,
  input  wire pps_pkg::load_wr_t          load_wr,
  input  wire pps_pkg::upd_wr_t           upd_wr,
  input  wire pps_pkg::scan_tok_t         tok_in,
  output pps_pkg::scan_tok_t              tok_out
);
  import pps_pkg::*;

  logic [PRIO_W-1:0]  prio;
  logic [ARR_W-1:0]   arr;
  logic [BURST_W-1:0] burst;
  logic [BURST_W-1:0] rem;
  logic               finished;

  logic active, arrived, eligible, pending, better, earlier;
  scan_tok_t tok_next;

  assign active   = CNT_W'(cell_index) < load_cnt;
  assign arrived  = TICK_W'(arr) <= tick;
  assign eligible = active && !finished && arrived;
  assign pending  = active && !finished && !arrived;
  assign better   = !tok_in.found || (prio < tok_in.prio) ||
                    ((prio == tok_in.prio) && (arr < tok_in.arr));
  assign earlier  = !tok_in.nfound || (arr < tok_in.narr);

  always_comb begin
    tok_next = tok_in;
    if (eligible && better) begin
      tok_next.found = 1'b1;
      tok_next.idx   = cell_index;
      tok_next.prio  = prio;
      tok_next.arr   = arr;
      tok_next.rem   = rem;
      tok_next.burst = burst;
    end
    if (pending && earlier) begin
      tok_next.nfound = 1'b1;
      tok_next.narr   = arr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_wr.en && (load_wr.idx == cell_index)) begin
      prio  <= load_wr.prio;
      arr   <= load_wr.arr;
      burst <= load_wr.burst;
      rem   <= load_wr.burst;
    end else if (upd_wr.en && (upd_wr.idx == cell_index)) begin
      rem <= upd_wr.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finished <= 1'b0;
    end else if (load_wr.en && (load_wr.idx == cell_index)) begin
      finished <= 1'b0;
    end else if (upd_wr.en && (upd_wr.idx == cell_index) && upd_wr.done) begin
      finished <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== design/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler. Process entries (priority, arrival, burst) are taken one
// transfer per cycle into a row of MAX_PROCESSES cells; entries beyond that are dropped.
// The entry marked final_entry starts an event-driven run from tick 0: a scan token walks
// the cell row, one cell per cycle, collecting the most urgent arrived unfinished entry
// (lowest priority number, then earliest arrival, then lowest index) and the next future
// arrival. The chosen entry runs until it finishes or the next arrival, whichever comes
// first; with nothing arrived the clock jumps to the next arrival. Each decision is a full
// scan through the cell row and a CALC step, and a completion adds the TAT and EMIT states
// and waits out any result back-pressure; a run of N entries makes at most 2N decisions.
// No entry is taken while a run is in progress. Results come out in completion order,
// the final one flagged by last_result, then the batch clears and loading resumes.
// Depends on pps_pkg, pps_ifs, pps_cell and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "preemptive_priority_scheduler_assert.svh"
module preemptive_priority_scheduler (
  input wire logic    clk,
  input wire logic    rst,
  pps_entry_if.sink   entry,
  pps_result_if.source result
);
  import pps_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_STEP = 3'd3;
  localparam logic [2:0] ST_TAT  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]         state;
  logic [CNT_W-1:0]   load_cnt;
  logic [CNT_W-1:0]   fin_cnt;
  logic [TICK_W-1:0]  tick;
  logic               scan_busy;
  scan_tok_t          res;      // latched scan outcome for the current decision
  logic [BURST_W-1:0] run;      // ticks to run the chosen entry
  logic [TICK_W-1:0]  tat;
  logic               out_valid;

  // cell row: tok[0] is the launch slot, tok[MAX_PROCESSES] the end of the chain
  scan_tok_t tok [0:MAX_PROCESSES];
  scan_tok_t tok_end;
  load_wr_t  load_wr;
  upd_wr_t   upd_wr;
  logic      launch;
  logic      entry_xfer;
  logic      out_free;

  logic [TICK_W-1:0]  diff;
  logic [BURST_W-1:0] rem_new;
  logic [TICK_W-1:0]  wt;
  logic [31:0]        idx32, tick32, tat32, wt32;

  assign entry.ready = (state == ST_IDLE);
  assign entry_xfer  = entry.valid && entry.ready;
  assign out_free    = !out_valid || result.ready;
  assign launch      = (state == ST_SCAN) && !scan_busy;

  assign tok[0]  = '{valid: launch, default: '0};
  assign tok_end = tok[MAX_PROCESSES];

  // entry write into the next free cell
  always_comb begin
    load_wr       = '0;
    load_wr.en    = entry_xfer && (load_cnt < CNT_W'(MAX_PROCESSES));
    load_wr.idx   = load_cnt[IDX_W-1:0];
    load_wr.prio  = entry.priority_level;
    load_wr.arr   = entry.arrival_tick;
    load_wr.burst = entry.burst_ticks;
  end

  // remaining-time write back after a run step
  assign rem_new = res.rem - run;
  always_comb begin
    upd_wr      = '0;
    upd_wr.en   = (state == ST_STEP);
    upd_wr.idx  = res.idx;
    upd_wr.rem  = rem_new;
    upd_wr.done = (rem_new == '0);
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_PROCESSES; gi++) begin : g_cell
      pps_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cell_index (IDX_W'(gi)),
        .load_cnt   (load_cnt),
        .tick       (tick),
        .load_wr    (load_wr),
        .upd_wr     (upd_wr),
        .tok_in     (tok[gi]),
        .tok_out    (tok[gi+1])
      );
    end
  endgenerate

  assign diff = TICK_W'(res.narr) - tick;
  assign wt   = tat - TICK_W'(res.burst);

  assign idx32  = 32'(res.idx);
  assign tick32 = 32'(tick);
  assign tat32  = 32'(tat);
  assign wt32   = 32'(wt);

  // payload registers for the next decision and the result
  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && tok_end.valid) begin
      res <= tok_end;
    end
    if (state == ST_CALC) begin
      // preemption only happens at an arrival: stop there if it comes first
      if (res.nfound && (diff < TICK_W'(res.rem))) begin
        run <= diff[BURST_W-1:0];
      end else begin
        run <= res.rem;
      end
    end
    if (state == ST_TAT) begin
      tat <= tick - TICK_W'(res.arr);
    end
    if ((state == ST_EMIT) && out_free) begin
      result.process_id       <= idx32[PID_W-1:0];
      result.finish_tick      <= tick32[FINISH_W-1:0];
      result.turnaround_ticks <= tat32[TAT_W-1:0];
      result.waiting_ticks    <= wt32[WAIT_W-1:0];
      result.last_result      <= (fin_cnt == load_cnt);
    end
  end

  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      load_cnt  <= '0;
      fin_cnt   <= '0;
      tick      <= '0;
      scan_busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if ((state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (entry_xfer) begin
            if (load_wr.en) begin
              load_cnt <= load_cnt + CNT_W'(1);
            end
            if (entry.final_entry) begin
              tick  <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (launch) begin
            scan_busy <= 1'b1;
          end
          if (tok_end.valid) begin
            scan_busy <= 1'b0;
            state     <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (res.found) begin
            state <= ST_STEP;
          end else begin
            // nothing ready: idle until the next arrival
            tick  <= TICK_W'(res.narr);
            state <= ST_SCAN;
          end
        end
        ST_STEP: begin
          tick <= tick + TICK_W'(run);
          if (upd_wr.done) begin
            fin_cnt <= fin_cnt + CNT_W'(1);
            state   <= ST_TAT;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_TAT: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (fin_cnt == load_cnt) begin
              load_cnt <= '0;
              fin_cnt  <= '0;
              tick     <= '0;
              state    <= ST_IDLE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PPS_ASSERT_IMP(a_fin_within_load, 1'b1, fin_cnt <= load_cnt)
  `PPS_ASSERT_IMP(a_tok_only_in_scan, tok_end.valid, state == ST_SCAN)
  `PPS_ASSERT_NXT(a_scan_to_calc, (state == ST_SCAN) && tok_end.valid, state == ST_CALC)
  `PPS_ASSERT_IMP(a_calc_has_work, state == ST_CALC, res.found || res.nfound)
  `PPS_ASSERT_IMP(a_emit_after_finish, state == ST_EMIT, fin_cnt != '0)
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for preemptive_priority_scheduler: process-entry loads in, completion
// records out, checked against an in-bench scheduling predictor.
// Depends on pps_pkg, pps_ifs and the scheduler RTL.
`timescale 1ns / 1ps
module tb;
  import pps_pkg::*;

  // One process entry as it crosses the entry channel.
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic               is_final;
  } proc_entry_t;

  // One completion record as it crosses the result channel.
  typedef struct packed {
    logic [PID_W-1:0]    pid;
    logic [FINISH_W-1:0] finish;
    logic [TAT_W-1:0]    turnaround;
    logic [WAIT_W-1:0]   waiting;
    logic                last;
  } completion_t;

  // Directed row: stimulus, plus a hand-typed completion where one is obvious.
  typedef struct packed {
    proc_entry_t stim;
    logic        typed;
    completion_t ans;
  } dir_row_t;

  localparam int          CLK_HALF     = 5;
  localparam int          RESET_CYCLES = 8;
  localparam int          RANDOM_ITEMS = 380;
  localparam int          DRAIN_CYCLES = 4 * (MAX_PROCESSES + 3);
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          SHOW_MAX     = 10;
  localparam int          NUM_DIR      = 16;
  localparam completion_t NO_ANS       = '0;

  // Single-entry batches carry their answer in the row; multi-entry batches go
  // through the predictor.
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    // lone entry straight after reset
    '{'{8'd0,   16'd0,     16'd1,     1'b1}, 1'b1, '{5'd0, 22'd1,      21'd1,     21'd0, 1'b1}},
    // every field at its top value
    '{'{8'd255, 16'd65535, 16'd65535, 1'b1}, 1'b1, '{5'd0, 22'd131070, 21'd65535, 21'd0, 1'b1}},
    // zero burst: done the moment it is picked
    '{'{8'd7,   16'd5,     16'd0,     1'b1}, 1'b1, '{5'd0, 22'd5,      21'd0,     21'd0, 1'b1}},
    // longest burst from tick zero
    '{'{8'd0,   16'd0,     16'd65535, 1'b1}, 1'b1, '{5'd0, 22'd65535,  21'd65535, 21'd0, 1'b1}},
    // preemption, tie on priority broken by arrival, then by index
    '{'{8'd4,   16'd0,     16'd8,     1'b0}, 1'b0, NO_ANS},
    '{'{8'd2,   16'd3,     16'd5,     1'b0}, 1'b0, NO_ANS},
    '{'{8'd2,   16'd3,     16'd2,     1'b0}, 1'b0, NO_ANS},
    '{'{8'd2,   16'd1,     16'd3,     1'b0}, 1'b0, NO_ANS},
    '{'{8'd0,   16'd20,    16'd1,     1'b1}, 1'b0, NO_ANS},
    // nothing arrived at tick zero: idle jump to the earliest arrival
    '{'{8'd5,   16'd100,   16'd3,     1'b0}, 1'b0, NO_ANS},
    '{'{8'd5,   16'd50,    16'd2,     1'b1}, 1'b0, NO_ANS},
    // zero burst preempting a running entry
    '{'{8'd1,   16'd0,     16'd4,     1'b0}, 1'b0, NO_ANS},
    '{'{8'd0,   16'd2,     16'd0,     1'b0}, 1'b0, NO_ANS},
    '{'{8'd255, 16'd0,     16'd1,     1'b1}, 1'b0, NO_ANS},
    // priority extremes arriving together at the last tick
    '{'{8'd255, 16'd65535, 16'd1,     1'b0}, 1'b0, NO_ANS},
    '{'{8'd0,   16'd65535, 16'd65535, 1'b1}, 1'b0, NO_ANS}
  };

  logic clk;
  logic rst;

  pps_entry_if  entry_ch ();
  pps_result_if result_ch ();

  preemptive_priority_scheduler u_top (
    .clk    (clk),
    .rst    (rst),
    .entry  (entry_ch),
    .result (result_ch)
  );

  // Predictor copy of the process table.
  logic [PRIO_W-1:0]  tbl_prio    [MAX_PROCESSES];
  logic [ARR_W-1:0]   tbl_arrival [MAX_PROCESSES];
  logic [BURST_W-1:0] tbl_burst   [MAX_PROCESSES];
  logic [BURST_W-1:0] tbl_left    [MAX_PROCESSES];
  bit                 tbl_done    [MAX_PROCESSES];
  int                 tbl_loaded;

  completion_t pending_q [$];  // completions still owed by the block
  int          fail_count;
  int          cycle_count;
  bit          calm;           // suppresses idling on both channels

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Loads one accepted entry into the predictor table; a final entry then runs
  // the whole batch and queues its completions (unless the row typed them).
  function automatic void predict_schedule(proc_entry_t e, bit queue_results);
    int          tick;
    int          done_cnt;
    int          sel;
    int          nxt;
    int          run;
    bit          more;
    completion_t c;
    if (tbl_loaded < MAX_PROCESSES) begin
      tbl_prio[tbl_loaded]    = e.prio;
      tbl_arrival[tbl_loaded] = e.arrival;
      tbl_burst[tbl_loaded]   = e.burst;
      tbl_left[tbl_loaded]    = e.burst;
      tbl_done[tbl_loaded]    = 1'b0;
      tbl_loaded++;
    end
    // entries past the table size are dropped, final flag still honored
    if (!e.is_final) return;
    tick = 0;
    done_cnt = 0;
    while (done_cnt < tbl_loaded) begin
      sel = -1;
      more = 1'b0;
      nxt = 0;
      for (int i = 0; i < tbl_loaded; i++) begin
        if (tbl_done[i]) continue;
        if (int'(tbl_arrival[i]) <= tick) begin
          if (sel < 0 || tbl_prio[i] < tbl_prio[sel] ||
              (tbl_prio[i] == tbl_prio[sel] && tbl_arrival[i] < tbl_arrival[sel]))
            sel = i;
        end else if (!more || int'(tbl_arrival[i]) < nxt) begin
          nxt = int'(tbl_arrival[i]);
          more = 1'b1;
        end
      end
      if (sel < 0) begin
        tick = nxt;  // idle until something arrives
      end else begin
        // a preemption can only happen at an arrival
        run = int'(tbl_left[sel]);
        if (more && nxt - tick < run) run = nxt - tick;
        tick += run;
        tbl_left[sel] = tbl_left[sel] - BURST_W'(run);
        if (tbl_left[sel] == '0) begin
          tbl_done[sel] = 1'b1;
          done_cnt++;
          c.pid        = PID_W'(sel);
          c.finish     = FINISH_W'(tick);
          c.turnaround = TAT_W'(tick - int'(tbl_arrival[sel]));
          c.waiting    = WAIT_W'(tick - int'(tbl_arrival[sel]) - int'(tbl_burst[sel]));
          c.last       = (done_cnt == tbl_loaded);
          if (queue_results) pending_q.push_back(c);
        end
      end
    end
    tbl_loaded = 0;
    for (int i = 0; i < MAX_PROCESSES; i++) tbl_done[i] = 1'b0;
  endfunction

  // Offers one entry, with random idle cycles first, and returns at the edge
  // where the transfer happens.
  task automatic offer_entry(proc_entry_t e);
    while (!calm && $urandom_range(0, 99) < 33) begin
      entry_ch.valid <= 1'b0;
      @(posedge clk);
    end
    entry_ch.valid          <= 1'b1;
    entry_ch.priority_level <= e.prio;
    entry_ch.arrival_tick   <= e.arrival;
    entry_ch.burst_ticks    <= e.burst;
    entry_ch.final_entry    <= e.is_final;
    do @(posedge clk); while (entry_ch.ready !== 1'b1);
  endtask

  // Result sink: random stalls on ready, compare every transfer in order.
  initial result_ch.ready = 1'b0;
  always @(posedge clk) begin
    completion_t got;
    completion_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 33);
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        got.pid        = result_ch.process_id;
        got.finish     = result_ch.finish_tick;
        got.turnaround = result_ch.turnaround_ticks;
        got.waiting    = result_ch.waiting_ticks;
        got.last       = result_ch.last_result;
        if (pending_q.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_MAX)
            $display("unexpected result: pid %0d finish %0d tat %0d wait %0d last %0b",
                     got.pid, got.finish, got.turnaround, got.waiting, got.last);
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= SHOW_MAX)
              $display({"mismatch: exp pid %0d finish %0d tat %0d wait %0d last %0b",
                        " / got pid %0d finish %0d tat %0d wait %0d last %0b"},
                       want.pid, want.finish, want.turnaround, want.waiting, want.last,
                       got.pid, got.finish, got.turnaround, got.waiting, got.last);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("preemptive_priority_scheduler verification failed");
      $finish;
    end
  end

  initial begin
    proc_entry_t e;
    int          random_sent;
    int          batch_len;
    int          arr_mode;
    int          prio_wide;
    int          arr_base;
    int          pick;
    fail_count  = 0;
    cycle_count = 0;
    calm        = 1'b0;
    tbl_loaded  = 0;
    for (int i = 0; i < MAX_PROCESSES; i++) tbl_done[i] = 1'b0;
    entry_ch.valid          = 1'b0;
    entry_ch.priority_level = '0;
    entry_ch.arrival_tick   = '0;
    entry_ch.burst_ticks    = '0;
    entry_ch.final_entry    = 1'b0;
    rst = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int r = 0; r < NUM_DIR; r++) begin
      offer_entry(DIR_ROWS[r].stim);
      predict_schedule(DIR_ROWS[r].stim, !DIR_ROWS[r].typed);
      if (DIR_ROWS[r].typed) pending_q.push_back(DIR_ROWS[r].ans);
    end

    // Random batches: mostly short, some filling the table, a few overflowing it.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6)       batch_len = $urandom_range(MAX_PROCESSES, MAX_PROCESSES + 4);
      else if (pick < 14) batch_len = $urandom_range(16, MAX_PROCESSES);
      else                batch_len = $urandom_range(1, 10);
      arr_mode  = $urandom_range(0, 2);
      prio_wide = $urandom_range(0, 3) == 0;
      arr_base  = $urandom_range(0, 65535 - 31);
      for (int k = 0; k < batch_len; k++) begin
        // one long quiet stretch with no idling on either side
        calm = (random_sent >= 140 && random_sent < 220);
        e.prio = prio_wide ? PRIO_W'($urandom_range(0, 255)) : PRIO_W'($urandom_range(0, 3));
        case (arr_mode)
          0: begin
            e.arrival = ARR_W'($urandom_range(0, 30));  // heavy contention
          end
          1: begin
            e.arrival = ARR_W'($urandom_range(0, 65535));
          end
          default: begin
            e.arrival = ARR_W'(arr_base + $urandom_range(0, 31));  // cluster of close arrivals
          end
        endcase
        pick = $urandom_range(0, 15);
        if (pick == 0)      e.burst = '0;
        else if (pick == 1) e.burst = '1;
        else if (pick < 5)  e.burst = BURST_W'($urandom_range(1, 65535));
        else                e.burst = BURST_W'($urandom_range(1, 20));
        e.is_final = (k == batch_len - 1);
        offer_entry(e);
        predict_schedule(e, 1'b1);
        random_sent++;
      end
    end
    calm = 1'b0;
    entry_ch.valid <= 1'b0;

    // Let the last batch drain, then give stray results time to show up.
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("preemptive_priority_scheduler verification clean");
    else
      $display("preemptive_priority_scheduler verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/pps_pkg.sv
design/pps_ifs.sv
design/pps_cell.sv
design/preemptive_priority_scheduler.sv
tb/tb.sv
